[design/lmrf_pkg.sv]
// ----------------------------------------------------------------------------
// lmrf_pkg
// Shared types and constants for the lane marking ridge filter.
// ----------------------------------------------------------------------------
package lmrf_pkg;

  localparam int MAX_ROW_WIDTH = 4096;
  localparam int MIN_ROW_WIDTH = 9;
  localparam int WIN_LEN       = 9;
  localparam int EDGE          = 4;
  localparam int FLUSH_LEN     = 4;

  localparam int WIDTH_W = 13;   // row width register
  localparam int COL_W   = 12;   // column index
  localparam int SUM_W   = 10;   // sum of three pixels
  localparam int CFG_W   = 13;   // widest register

  localparam logic [7:0] MASK_ALLOWED = 8'hFF;

  typedef enum logic [1:0] {
    REG_ROW_WIDTH        = 2'd0,
    REG_BALANCE_LIMIT    = 2'd1,
    REG_MIDDLE_MINIMUM   = 2'd2,
    REG_RESPONSE_MINIMUM = 2'd3
  } lmrf_reg_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic [7:0] mask_byte;
  } lmrf_in_t;

  typedef struct packed {
    logic              lane_pixel;
    logic [COL_W-1:0]  column;
    logic              row_end;
  } lmrf_out_t;

  // Window stage record handed to the output sequencer.
  typedef struct packed {
    logic              valid;
    logic              has_dec;   // a decision is due for col
    logic              edge_ok;   // col lies inside the usable band
    logic              flush;     // pixel closes the row
    logic              mask_ok;
    logic [COL_W-1:0]  col;
    logic [SUM_W-1:0]  left_sum;
    logic [SUM_W-1:0]  mid_sum;
    logic [SUM_W-1:0]  right_sum;
  } lmrf_stage_t;

endpackage

[design/lane_marking_ridge_filter.sv]
// ----------------------------------------------------------------------------
// lane_marking_ridge_filter
// Path: the decision for column c is made from the window stage record that is
//   registered when the item for column c+4 is accepted, then the output register.
// Throughput: one item per cycle while the output is free; the item that ends a row
//   also yields four flush results, and input stalls while they go out (output port bound).
// Reset: synchronous, clears control and loads register reset values.
// ----------------------------------------------------------------------------
module lane_marking_ridge_filter
  import lmrf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lmrf_in_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output lmrf_out_t        out_item,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // Configuration registers
  logic [WIDTH_W-1:0] row_width;
  logic [9:0]         balance_limit;
  logic [10:0]        middle_minimum;
  logic signed [11:0] response_minimum;

  logic [WIDTH_W-1:0] eff_width;
  lmrf_stage_t        stage;
  logic               stage_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width        <= WIDTH_W'(640);
      balance_limit    <= 10'd100;
      middle_minimum   <= 11'd400;
      response_minimum <= 12'sd200;
    end else if (cfg_write) begin
      unique case (lmrf_reg_t'(cfg_index))
        REG_ROW_WIDTH:        row_width        <= cfg_data[WIDTH_W-1:0];
        REG_BALANCE_LIMIT:    balance_limit    <= cfg_data[9:0];
        REG_MIDDLE_MINIMUM:   middle_minimum   <= cfg_data[10:0];
        REG_RESPONSE_MINIMUM: response_minimum <= $signed(cfg_data[11:0]);
      endcase
    end
  end

  // Row width saturated to the supported range
  always_comb begin
    priority if (row_width < WIDTH_W'(MIN_ROW_WIDTH)) begin
      eff_width = WIDTH_W'(MIN_ROW_WIDTH);
    end else if (row_width > WIDTH_W'(MAX_ROW_WIDTH)) begin
      eff_width = WIDTH_W'(MAX_ROW_WIDTH);
    end else begin
      eff_width = row_width;
    end
  end

  // Pixel chain: shifts one cell per accepted item, registers the three sums
  lmrf_window u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .eff_width (eff_width),
    .stage_take(stage_take),
    .stage     (stage)
  );

  // Decision, row-end flush burst, output register
  lmrf_out u_out (
    .clk             (clk),
    .rst             (rst),
    .stage           (stage),
    .balance_limit   (balance_limit),
    .middle_minimum  (middle_minimum),
    .response_minimum(response_minimum),
    .stage_take      (stage_take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item)
  );

endmodule

[design/lmrf_cell.sv]
// ----------------------------------------------------------------------------
// lmrf_cell
// One window cell: holds a pixel and its mask byte, loads from its neighbor (the head cell from the input).
// ----------------------------------------------------------------------------
module lmrf_cell
  import lmrf_pkg::*;
(
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] pix_in,
  input  logic [7:0] mask_in,
  output logic [7:0] pix,
  output logic [7:0] mask
);

  always_ff @(posedge clk) begin
    if (shift) begin
      pix  <= pix_in;
      mask <= mask_in;
    end
  end

endmodule

[design/lmrf_window.sv]
// ----------------------------------------------------------------------------
// lmrf_window
// Nine-cell pixel chain, column counter and the registered window sums.
// ----------------------------------------------------------------------------
module lmrf_window
  import lmrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lmrf_in_t           in_item,
  input  logic [WIDTH_W-1:0] eff_width,
  input  logic               stage_take,
  output lmrf_stage_t        stage
);

  logic [7:0]       cell_pix  [WIN_LEN];
  logic [7:0]       cell_mask [WIN_LEN];
  logic             accept;
  logic [COL_W-1:0] col_cnt;
  logic             row_done;

  assign in_ready = !stage.valid || stage_take;
  assign accept   = in_valid && in_ready;

  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    if (i == WIN_LEN - 1) begin : g_head
      lmrf_cell u_cell (
        .clk    (clk),
        .shift  (accept),
        .pix_in (in_item.pixel),
        .mask_in(in_item.mask_byte),
        .pix    (cell_pix[i]),
        .mask   (cell_mask[i])
      );
    end else begin : g_body
      lmrf_cell u_cell (
        .clk    (clk),
        .shift  (accept),
        .pix_in (cell_pix[i+1]),
        .mask_in(cell_mask[i+1]),
        .pix    (cell_pix[i]),
        .mask   (cell_mask[i])
      );
    end
  end

  // Row ends at the first column at or past width-1.
  assign row_done = {1'b0, col_cnt} >= (eff_width - WIDTH_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt     <= '0;
      stage.valid <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt     <= row_done ? '0 : col_cnt + COL_W'(1);
        stage.valid <= 1'b1;
      end else if (stage_take) begin
        stage.valid <= 1'b0;
      end
    end
    // Sums use the window as it stands after this shift.
    if (accept) begin
      stage.has_dec   <= col_cnt >= COL_W'(EDGE);
      stage.edge_ok   <= (col_cnt >= COL_W'(2 * EDGE)) && !row_done;
      stage.flush     <= row_done;
      stage.mask_ok   <= cell_mask[EDGE+1] == MASK_ALLOWED;
      stage.col       <= col_cnt - COL_W'(EDGE);
      stage.left_sum  <= SUM_W'(cell_pix[1]) + SUM_W'(cell_pix[2]) + SUM_W'(cell_pix[3]);
      stage.mid_sum   <= SUM_W'(cell_pix[4]) + SUM_W'(cell_pix[5]) + SUM_W'(cell_pix[6]);
      stage.right_sum <= SUM_W'(cell_pix[7]) + SUM_W'(cell_pix[8]) + SUM_W'(in_item.pixel);
    end
  end

  a_flush_has_dec: assert property (@(posedge clk) disable iff (rst)
    stage.valid && stage.flush |-> stage.has_dec)
    else $error("row end without a due decision");

  a_edge_needs_dec: assert property (@(posedge clk) disable iff (rst)
    stage.valid && stage.edge_ok |-> stage.has_dec && !stage.flush)
    else $error("edge band flag inconsistent");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    stage.valid && !stage_take |=> stage.valid && $stable(stage.col))
    else $error("stage record lost while stalled");

endmodule

[design/lmrf_out.sv]
// ----------------------------------------------------------------------------
// lmrf_out
// Threshold decision, row-end flush burst and the output register.
// ----------------------------------------------------------------------------
module lmrf_out
  import lmrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  lmrf_stage_t        stage,
  input  logic [9:0]         balance_limit,
  input  logic [10:0]        middle_minimum,
  input  logic signed [11:0] response_minimum,
  output logic               stage_take,
  output logic               out_valid,
  input  logic               out_ready,
  output lmrf_out_t          out_item
);

  logic [2:0]         burst_cnt;
  logic [COL_W-1:0]   burst_col;
  logic               out_free;
  logic [SUM_W-1:0]   side_diff;
  logic signed [12:0] resp;
  logic               lane;
  logic               load_burst;
  logic               load_dec;

  assign out_free   = !out_valid || out_ready;
  assign stage_take = stage.valid && (burst_cnt == 3'd0) && out_free;
  assign load_burst = (burst_cnt != 3'd0) && out_free;
  assign load_dec   = stage_take && stage.has_dec;

  // |L - R| equals |right - left| of the raw sums
  assign side_diff = (stage.right_sum >= stage.left_sum) ?
                     stage.right_sum - stage.left_sum :
                     stage.left_sum - stage.right_sum;

  assign resp = $signed({2'b00, stage.mid_sum, 1'b0})
              - $signed({3'b000, stage.left_sum})
              - $signed({3'b000, stage.right_sum});

  assign lane = stage.edge_ok && stage.mask_ok
             && (side_diff <= balance_limit)
             && ({stage.mid_sum, 1'b0} >= middle_minimum)
             && (resp > 13'(response_minimum));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      burst_cnt <= '0;
    end else begin
      if (load_burst) begin
        out_valid <= 1'b1;
        burst_cnt <= burst_cnt - 3'd1;
      end else if (load_dec) begin
        out_valid <= 1'b1;
        burst_cnt <= stage.flush ? 3'(FLUSH_LEN) : 3'd0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_burst) begin
      out_item.lane_pixel <= 1'b0;
      out_item.column     <= burst_col;
      out_item.row_end    <= burst_cnt == 3'd1;
      burst_col           <= burst_col + COL_W'(1);
    end else if (load_dec) begin
      out_item.lane_pixel <= lane;
      out_item.column     <= stage.col;
      out_item.row_end    <= 1'b0;
      burst_col           <= stage.col + COL_W'(1);
    end
  end

  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    load_dec && stage.flush |=> burst_cnt == 3'(FLUSH_LEN))
    else $error("flush burst not started");

  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.row_end |-> burst_cnt == 3'd0 && !out_item.lane_pixel)
    else $error("row end item out of place");

  a_burst_range: assert property (@(posedge clk) disable iff (rst)
    burst_cnt <= 3'(FLUSH_LEN))
    else $error("burst count out of range");

endmodule
